// ===== rtl/tmvg_pkg.sv =====
// shared types, constants and tables of the torus mesh vertex generator
// no dependencies

package tmvg_pkg;

	localparam int DEF_MAX_SIDES  = 256;
	localparam int DEF_MAX_RINGS  = 256;
	localparam int DEF_PHASE_BITS = 16;

	localparam int RING_W   = 9;
	localparam int SIDE_W   = 8;
	localparam int COUNT_W  = 9;
	localparam int RADIUS_W = 16;
	localparam int INDEX_W  = 17;
	localparam int CORDIC_W = 34;
	localparam int CORDIC_STEPS = 16;

	localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

	localparam logic [RADIUS_W-1:0] OUTER_RESET = 16'd256;
	localparam logic [RADIUS_W-1:0] INNER_RESET = 16'd128;
	localparam logic [COUNT_W-1:0]  SIDES_RESET = 9'd16;
	localparam logic [COUNT_W-1:0]  RINGS_RESET = 9'd16;

	typedef enum logic [1:0] {
		REG_OUTER = 2'd0,
		REG_INNER = 2'd1,
		REG_SIDES = 2'd2,
		REG_RINGS = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		QUAD_0 = 2'd0,
		QUAD_1 = 2'd1,
		QUAD_2 = 2'd2,
		QUAD_3 = 2'd3
	} quad_t;

	typedef struct packed {
		logic [INDEX_W-1:0] a;
		logic [INDEX_W-1:0] b;
		logic [INDEX_W-1:0] c;
		logic [INDEX_W-1:0] d;
		logic               quad;
	} corner_t;

	typedef struct packed {
		logic signed [CORDIC_W-1:0] x;
		logic signed [CORDIC_W-1:0] y;
		logic signed [CORDIC_W-1:0] z;
		quad_t                      q;
	} cordic_t;

	// atan(2^-i), full turn = 2^32
	function automatic logic signed [CORDIC_W-1:0] atan_at(input int i);
		logic signed [CORDIC_W-1:0] v;
		case (i)
			0:       v = 34'sh20000000;
			1:       v = 34'sh12E4051E;
			2:       v = 34'sh09FB385B;
			3:       v = 34'sh051111D4;
			4:       v = 34'sh028B0D43;
			5:       v = 34'sh0145D7E1;
			6:       v = 34'sh00A2F61E;
			7:       v = 34'sh00517C55;
			8:       v = 34'sh0028BE53;
			9:       v = 34'sh00145F2F;
			10:      v = 34'sh000A2F98;
			11:      v = 34'sh000517CC;
			12:      v = 34'sh00028BE6;
			13:      v = 34'sh000145F3;
			14:      v = 34'sh0000A2FA;
			15:      v = 34'sh0000517D;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// ===== rtl/tmvg_phase_cell.sv =====
// one restoring division step for the ring and side phases
// depends on tmvg_pkg

module tmvg_phase_cell import tmvg_pkg::*; #(
	parameter int PHASE_BITS = DEF_PHASE_BITS,
	parameter int K = 0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic [COUNT_W-1:0]    rings,
	input  logic [COUNT_W-1:0]    sides,
	input  logic                  vld_i,
	input  logic [RING_W-1:0]     ring_i,
	input  logic [SIDE_W-1:0]     side_i,
	input  logic [COUNT_W-1:0]    rrem_i,
	input  logic [COUNT_W-1:0]    srem_i,
	input  logic [PHASE_BITS-1:0] rq_i,
	input  logic [PHASE_BITS-1:0] sq_i,
	input  corner_t               tag_i,
	output logic                  vld_o,
	output logic [RING_W-1:0]     ring_o,
	output logic [SIDE_W-1:0]     side_o,
	output logic [COUNT_W-1:0]    rrem_o,
	output logic [COUNT_W-1:0]    srem_o,
	output logic [PHASE_BITS-1:0] rq_o,
	output logic [PHASE_BITS-1:0] sq_o,
	output corner_t               tag_o
);

	localparam int J = RING_W + PHASE_BITS - 1 - K;

	logic             rbit, sbit;
	logic [COUNT_W:0] rtrial, strial;
	logic             rge, sge;

	generate
		if (J >= PHASE_BITS) begin : g_rbit
			assign rbit = ring_i[J-PHASE_BITS];
		end else begin : g_rzero
			assign rbit = 1'b0;
		end
		if (J >= PHASE_BITS && J - PHASE_BITS < SIDE_W) begin : g_sbit
			assign sbit = side_i[J-PHASE_BITS];
		end else begin : g_szero
			assign sbit = 1'b0;
		end
	endgenerate

	assign rtrial = {rrem_i, rbit};
	assign strial = {srem_i, sbit};
	assign rge    = rtrial >= {1'b0, rings};
	assign sge    = strial >= {1'b0, sides};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else if (en) begin
			vld_o <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ring_o <= ring_i;
			side_o <= side_i;
			tag_o  <= tag_i;
			rrem_o <= rge ? COUNT_W'(rtrial - {1'b0, rings}) : rtrial[COUNT_W-1:0];
			srem_o <= sge ? COUNT_W'(strial - {1'b0, sides}) : strial[COUNT_W-1:0];
			rq_o   <= {rq_i[PHASE_BITS-2:0], rge};
			sq_o   <= {sq_i[PHASE_BITS-2:0], sge};
		end
	end

endmodule

// ===== rtl/tmvg_cordic_cell.sv =====
// one cordic rotation step applied to the ring and side angles
// depends on tmvg_pkg

module tmvg_cordic_cell import tmvg_pkg::*; #(
	parameter int K = 0
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    en,
	input  logic    vld_i,
	input  cordic_t u_i,
	input  cordic_t v_i,
	input  corner_t tag_i,
	output logic    vld_o,
	output cordic_t u_o,
	output cordic_t v_o,
	output corner_t tag_o
);

	function automatic cordic_t rot(input cordic_t a);
		cordic_t b;
		logic signed [CORDIC_W-1:0] xs, ys;
		xs = a.x >>> K;
		ys = a.y >>> K;
		b  = a;
		if (!a.z[CORDIC_W-1]) begin
			b.x = a.x - ys;
			b.y = a.y + xs;
			b.z = a.z - atan_at(K);
		end else begin
			b.x = a.x + ys;
			b.y = a.y - xs;
			b.z = a.z + atan_at(K);
		end
		return b;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else if (en) begin
			vld_o <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			u_o   <= rot(u_i);
			v_o   <= rot(v_i);
			tag_o <= tag_i;
		end
	end

endmodule

// ===== rtl/tmvg_shade.sv =====
// cordic result rounding, position and normal arithmetic, output register
// depends on tmvg_pkg

module tmvg_shade import tmvg_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic [RADIUS_W-1:0]     outer,
	input  logic [RADIUS_W-1:0]     inner,
	input  logic                    vld_i,
	input  cordic_t                 u_i,
	input  cordic_t                 v_i,
	input  corner_t                 tag_i,
	output logic                    vld_o,
	output logic signed [31:0]      pos_x,
	output logic signed [31:0]      pos_y,
	output logic signed [31:0]      pos_z,
	output logic signed [15:0]      normal_x,
	output logic signed [15:0]      normal_y,
	output logic signed [15:0]      normal_z,
	output corner_t                 tag_o
);

	function automatic logic signed [15:0] unit16(input logic signed [CORDIC_W-1:0] v);
		logic signed [CORDIC_W-1:0] t;
		t = (v + 34'sd32768) >>> 16;
		if (t > 34'sd16384) t = 34'sd16384;
		if (t < -34'sd16384) t = -34'sd16384;
		return 16'(t);
	endfunction

	function automatic logic signed [15:0] norm16(input logic signed [31:0] v);
		logic signed [31:0] t;
		t = (v + 32'sd8192) >>> 14;
		if (t > 32'sd16384) t = 32'sd16384;
		if (t < -32'sd16384) t = -32'sd16384;
		return 16'(t);
	endfunction

	logic signed [15:0] cu, su, cv, sv;

	always_comb begin
		logic signed [15:0] ux, uy, vx, vy;
		ux = unit16(u_i.x);
		uy = unit16(u_i.y);
		vx = unit16(v_i.x);
		vy = unit16(v_i.y);
		case (u_i.q)
			QUAD_0:  begin cu = ux;  su = uy;  end
			QUAD_1:  begin cu = -uy; su = ux;  end
			QUAD_2:  begin cu = -ux; su = -uy; end
			default: begin cu = uy;  su = -ux; end
		endcase
		case (v_i.q)
			QUAD_0:  begin cv = vx;  sv = vy;  end
			QUAD_1:  begin cv = -vy; sv = vx;  end
			QUAD_2:  begin cv = -vx; sv = -vy; end
			default: begin cv = vy;  sv = -vx; end
		endcase
	end

	logic               vld_s1, vld_s2, vld_s3, vld_s4;
	corner_t            tag_s1, tag_s2, tag_s3, tag_s4;
	logic signed [15:0] cu_s1, su_s1, cv_s1, sv_s1;
	logic signed [15:0] cu_s2, su_s2, sv_s2;
	logic signed [32:0] icv_s2, isv_s2;
	logic signed [31:0] ncx_s2, ncy_s2;
	logic signed [15:0] cu_s3, su_s3, sv_s3, nx_s3, ny_s3;
	logic signed [33:0] r_s3;
	logic signed [31:0] pz_s3, pz_s4;
	logic signed [49:0] px_s4, py_s4;
	logic signed [15:0] nx_s4, ny_s4, nz_s4;
	logic signed [31:0] pos_x_q, pos_y_q, pos_z_q;
	logic signed [15:0] nx_q, ny_q, nz_q;
	corner_t            tag_q;
	logic               vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_q  <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_q  <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cu_s1  <= cu;
			su_s1  <= su;
			cv_s1  <= cv;
			sv_s1  <= sv;
			tag_s1 <= tag_i;

			icv_s2 <= $signed({1'b0, inner}) * cv_s1;
			isv_s2 <= $signed({1'b0, inner}) * sv_s1;
			ncx_s2 <= cv_s1 * cu_s1;
			ncy_s2 <= cv_s1 * su_s1;
			cu_s2  <= cu_s1;
			su_s2  <= su_s1;
			sv_s2  <= sv_s1;
			tag_s2 <= tag_s1;

			r_s3   <= $signed({4'b0, outer, 14'b0}) + 34'(icv_s2);
			pz_s3  <= 32'((isv_s2 + 33'sd32) >>> 6);
			nx_s3  <= norm16(ncx_s2);
			ny_s3  <= norm16(ncy_s2);
			cu_s3  <= cu_s2;
			su_s3  <= su_s2;
			sv_s3  <= sv_s2;
			tag_s3 <= tag_s2;

			px_s4  <= r_s3 * cu_s3;
			py_s4  <= r_s3 * su_s3;
			nx_s4  <= r_s3[33] ? -nx_s3 : nx_s3;
			ny_s4  <= r_s3[33] ? -ny_s3 : ny_s3;
			nz_s4  <= r_s3[33] ? -sv_s3 : sv_s3;
			pz_s4  <= pz_s3;
			tag_s4 <= tag_s3;

			pos_x_q <= 32'((px_s4 + 50'sd524288) >>> 20);
			pos_y_q <= 32'((py_s4 + 50'sd524288) >>> 20);
			pos_z_q <= pz_s4;
			nx_q    <= nx_s4;
			ny_q    <= ny_s4;
			nz_q    <= nz_s4;
			tag_q   <= tag_s4;
		end
	end

	assign vld_o    = vld_q;
	assign pos_x    = pos_x_q;
	assign pos_y    = pos_y_q;
	assign pos_z    = pos_z_q;
	assign normal_x = nx_q;
	assign normal_y = ny_q;
	assign normal_z = nz_q;
	assign tag_o    = tag_q;

endmodule

// ===== rtl/torus_mesh_vertex_generator_top.sv =====
// top level of the torus mesh vertex generator: config registers, corner indices,
// division and cordic cell chains, shading stages
// depends on tmvg_pkg, tmvg_phase_cell, tmvg_cordic_cell, tmvg_shade
//
// usage:
// - a request on the input channel (in_valid, in_stall) carries one grid point
//   (ring_index, side_index); the output channel (out_valid, out_stall) returns
//   its vertex position, normal and quad corners, one result per request
// - the config channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is always
//   ready; write it only while no request is in flight
// - the chain has one input stage, PHASE_BITS + 9 division cells that each
//   produce one quotient bit of both phases, one cordic entry stage, 16 cordic
//   cells and five shading stages
// - throughput is one request per cycle unless a result is stalled; every stage
//   moves together, so throughput is set by the single shared advance enable
// - when the receiver stalls a waiting result, the whole chain holds and
//   in_stall is raised in the same cycle; results are never dropped
// - reset empties the chain and loads outer 256, inner 128, 16 sides, 16 rings

module torus_mesh_vertex_generator_top import tmvg_pkg::*; #(
	parameter int MAX_SIDES  = DEF_MAX_SIDES,
	parameter int MAX_RINGS  = DEF_MAX_RINGS,
	parameter int PHASE_BITS = DEF_PHASE_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [1:0]           cfg_index,
	input  logic [15:0]          cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [RING_W-1:0]    ring_index,
	input  logic [SIDE_W-1:0]    side_index,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic signed [31:0]   pos_x,
	output logic signed [31:0]   pos_y,
	output logic signed [31:0]   pos_z,
	output logic signed [15:0]   normal_x,
	output logic signed [15:0]   normal_y,
	output logic signed [15:0]   normal_z,
	output logic [INDEX_W-1:0]   corner_a,
	output logic [INDEX_W-1:0]   corner_b,
	output logic [INDEX_W-1:0]   corner_c,
	output logic [INDEX_W-1:0]   corner_d,
	output logic                 quad_valid
);

	localparam int DW = RING_W + PHASE_BITS;

	logic [RADIUS_W-1:0] outer_q, inner_q;
	logic [COUNT_W-1:0]  sides_q, rings_q;
	logic [COUNT_W-1:0]  sides_eff, rings_eff;
	logic                en;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outer_q <= OUTER_RESET;
			inner_q <= INNER_RESET;
			sides_q <= SIDES_RESET;
			rings_q <= RINGS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_OUTER: outer_q <= cfg_data;
				REG_INNER: inner_q <= cfg_data;
				REG_SIDES: sides_q <= cfg_data[COUNT_W-1:0];
				REG_RINGS: rings_q <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign sides_eff = (sides_q == '0) ? COUNT_W'(1) :
	                   (int'(sides_q) > MAX_SIDES) ? COUNT_W'(MAX_SIDES) : sides_q;
	assign rings_eff = (rings_q == '0) ? COUNT_W'(1) :
	                   (int'(rings_q) > MAX_RINGS) ? COUNT_W'(MAX_RINGS) : rings_q;

	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	// corner indices of the quad starting at this point
	corner_t            tag_in;
	logic [17:0]        here, next;
	logic [COUNT_W-1:0] side_inc, nside;
	logic               is_quad;

	always_comb begin
		here     = 18'(ring_index * sides_eff);
		next     = here + 18'(sides_eff);
		side_inc = COUNT_W'(side_index) + COUNT_W'(1);
		nside    = (side_inc == sides_eff) ? '0 : side_inc;
		is_quad  = ({1'b0, ring_index} < {1'b0, rings_eff}) &&
		           ({1'b0, side_index} < sides_eff);
		tag_in   = '0;
		if (is_quad) begin
			tag_in.a    = INDEX_W'(here + 18'(side_index));
			tag_in.b    = INDEX_W'(next + 18'(side_index));
			tag_in.c    = INDEX_W'(next + 18'(nside));
			tag_in.d    = INDEX_W'(here + 18'(nside));
			tag_in.quad = 1'b1;
		end
	end

	logic              vld_s0;
	logic [RING_W-1:0] ring_s0;
	logic [SIDE_W-1:0] side_s0;
	corner_t           tag_s0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s0 <= 1'b0;
		end else if (en) begin
			vld_s0 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ring_s0 <= ring_index;
			side_s0 <= side_index;
			tag_s0  <= tag_in;
		end
	end

	// division chain
	logic                  pv    [0:DW];
	logic [RING_W-1:0]     pring [0:DW];
	logic [SIDE_W-1:0]     pside [0:DW];
	logic [COUNT_W-1:0]    prrem [0:DW];
	logic [COUNT_W-1:0]    psrem [0:DW];
	logic [PHASE_BITS-1:0] prq   [0:DW];
	logic [PHASE_BITS-1:0] psq   [0:DW];
	corner_t               ptag  [0:DW];

	assign pv[0]    = vld_s0;
	assign pring[0] = ring_s0;
	assign pside[0] = side_s0;
	assign prrem[0] = '0;
	assign psrem[0] = '0;
	assign prq[0]   = '0;
	assign psq[0]   = '0;
	assign ptag[0]  = tag_s0;

	for (genvar k = 0; k < DW; k++) begin : g_div
		tmvg_phase_cell #(.PHASE_BITS(PHASE_BITS), .K(k)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.rings  (rings_eff),
			.sides  (sides_eff),
			.vld_i  (pv[k]),
			.ring_i (pring[k]),
			.side_i (pside[k]),
			.rrem_i (prrem[k]),
			.srem_i (psrem[k]),
			.rq_i   (prq[k]),
			.sq_i   (psq[k]),
			.tag_i  (ptag[k]),
			.vld_o  (pv[k+1]),
			.ring_o (pring[k+1]),
			.side_o (pside[k+1]),
			.rrem_o (prrem[k+1]),
			.srem_o (psrem[k+1]),
			.rq_o   (prq[k+1]),
			.sq_o   (psq[k+1]),
			.tag_o  (ptag[k+1])
		);
	end

	// cordic entry: quadrant fold
	function automatic cordic_t fold(input logic [PHASE_BITS-1:0] ph);
		cordic_t    c;
		logic [31:0] p, s, d;
		p   = {ph, {(32 - PHASE_BITS){1'b0}}};
		s   = p + 32'h2000_0000;
		c.q = quad_t'(s[31:30]);
		d   = p - {s[31:30], 30'b0};
		c.x = CORDIC_GAIN;
		c.y = '0;
		c.z = CORDIC_W'($signed(d));
		return c;
	endfunction

	logic    cv   [0:CORDIC_STEPS];
	cordic_t cu   [0:CORDIC_STEPS];
	cordic_t cvv  [0:CORDIC_STEPS];
	corner_t ctag [0:CORDIC_STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cv[0] <= 1'b0;
		end else if (en) begin
			cv[0] <= pv[DW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cu[0]   <= fold(prq[DW]);
			cvv[0]  <= fold(psq[DW]);
			ctag[0] <= ptag[DW];
		end
	end

	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_rot
		tmvg_cordic_cell #(.K(k)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.vld_i  (cv[k]),
			.u_i    (cu[k]),
			.v_i    (cvv[k]),
			.tag_i  (ctag[k]),
			.vld_o  (cv[k+1]),
			.u_o    (cu[k+1]),
			.v_o    (cvv[k+1]),
			.tag_o  (ctag[k+1])
		);
	end

	corner_t tag_out;

	tmvg_shade u_shade (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.outer    (outer_q),
		.inner    (inner_q),
		.vld_i    (cv[CORDIC_STEPS]),
		.u_i      (cu[CORDIC_STEPS]),
		.v_i      (cvv[CORDIC_STEPS]),
		.tag_i    (ctag[CORDIC_STEPS]),
		.vld_o    (out_valid),
		.pos_x    (pos_x),
		.pos_y    (pos_y),
		.pos_z    (pos_z),
		.normal_x (normal_x),
		.normal_y (normal_y),
		.normal_z (normal_z),
		.tag_o    (tag_out)
	);

	assign corner_a   = tag_out.a;
	assign corner_b   = tag_out.b;
	assign corner_c   = tag_out.c;
	assign corner_d   = tag_out.d;
	assign quad_valid = tag_out.quad;

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> vld_s0)
		else $error("accepted request did not enter the chain");

	a_stall_back: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall)
		else $error("input taken while output stalled");

	a_no_quad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !quad_valid |-> corner_a == '0 && corner_b == '0 &&
		corner_c == '0 && corner_d == '0)
		else $error("corners not cleared without a quad");

	a_normal_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> normal_x <= 16'sd16384 && normal_x >= -16'sd16384 &&
		normal_z <= 16'sd16384 && normal_z >= -16'sd16384)
		else $error("normal out of unit range");

endmodule
